### rtl/assert_macros.svh
// Assertion macros shared by the queue RTL.
// Depends on nothing; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define UPQ_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define UPQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define UPQ_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define UPQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/upq_pkg.sv
// Shared types, sizes and codes for the unsorted-array min priority queue.
// Used by the cell and the top level; depends on nothing else.
package upq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int CFG_W    = 7;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [1:0]               cell_op_t;
  typedef logic [1:0]               status_t;

  // Row-wide operations broadcast to every cell.
  localparam cell_op_t OP_HOLD   = 2'd0;
  localparam cell_op_t OP_PUSH   = 2'd1;
  localparam cell_op_t OP_POP    = 2'd2;
  localparam cell_op_t OP_BUBBLE = 2'd3;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam status_t ST_INSERTED = 2'd0;
  localparam status_t ST_DROPPED  = 2'd1;
  localparam status_t ST_REMOVED  = 2'd2;
  localparam status_t ST_EMPTY    = 2'd3;

  typedef struct packed {
    cell_op_t op;
    logic     arm;       // place the compare token at the last occupied cell
    idx_t     last_idx;
  } cell_ctrl_t;

endpackage

### rtl/upq_cell.sv
// One storage cell of the queue row: an entry, a compare token and a comparator.
// Depends on upq_pkg; talks only to its two neighbors and the broadcast control.
module upq_cell import upq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  idx_t       cell_idx,
  input  data_t      lo_val,
  input  data_t      hi_val,
  input  logic       hi_swap,
  input  logic       hi_tok,
  output data_t      val,
  output logic       swap,
  output logic       tok
);

  data_t val_r, val_nxt;
  logic  tok_r, tok_nxt;

  // The token marks the cell that compares itself with its lower neighbor this
  // cycle; the smaller of the two ends up in the lower cell.
  assign swap = tok_r && (ctrl.op == OP_BUBBLE) && ($signed(val_r) < $signed(lo_val));

  always_comb begin
    val_nxt = val_r;
    tok_nxt = 1'b0;
    if (ctrl.arm) begin
      tok_nxt = (cell_idx == ctrl.last_idx);
    end
    case (ctrl.op)
      OP_HOLD: begin
      end
      OP_PUSH: begin
        val_nxt = lo_val;
      end
      OP_POP: begin
        val_nxt = hi_val;
      end
      OP_BUBBLE: begin
        tok_nxt = hi_tok;
        if (swap) begin
          val_nxt = lo_val;
        end else if (hi_swap) begin
          val_nxt = hi_val;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign val = val_r;
  assign tok = tok_r;

endmodule

### rtl/unsorted_array_min_priority_queue_core.sv
// Top level of the min priority queue: control sequencer and the row of cells.
// Depends on upq_pkg, upq_cell and assert_macros.svh.
//
// Usage:
//   Requests enter on in_func / in_value and are taken at a clock edge where
//   start is high and busy is low. Every request gives exactly one result beat
//   on out_status / out_min_value / out_entry_count, marked by out_strobe for
//   one cycle; the receiver must take it then.
//   An insert's result shows the next cycle and busy stays low, so inserts can
//   follow back to back. A remove on an empty queue, or on a queue of one
//   entry, likewise leaves busy low, and its result shows the next cycle.
//   Otherwise a compare token walks down the row of cells from the last
//   occupied cell to the first, one cell a cycle, carrying the minimum down;
//   the remove holds busy through the walk and the pop from the first cell,
//   and its result shows in the first cycle that busy is low again.
//   cfg_we / cfg_wdata set the capacity limit; write it only while idle.
//   Reset empties the queue and sets the limit to the full capacity.
//   The result channel has no back-pressure.
`include "assert_macros.svh"
module unsorted_array_min_priority_queue_core import upq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic signed [31:0] in_value,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_min_value,
  output logic [6:0]         out_entry_count,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_BUBBLE  = 2'd1;
  localparam logic [1:0] S_EXTRACT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  cnt_t             count_r, count_nxt;
  idx_t             rem_r, rem_nxt;
  logic [CFG_W-1:0] limit_r;
  logic             out_strobe_r, out_strobe_nxt;
  status_t          out_status_r, out_status_nxt;
  data_t            out_min_r, out_min_nxt;
  cnt_t             out_count_r;

  cell_ctrl_t       ctrl;
  data_t            vals  [CAPACITY];
  logic [CAPACITY-1:0] swaps;
  logic [CAPACITY-1:0] toks;

  cnt_t  eff_limit;
  cnt_t  last_cnt;
  logic  accept;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign eff_limit = (limit_r > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : limit_r;
  assign last_cnt  = count_r - 1'b1;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rem_nxt        = rem_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = ST_INSERTED;
    out_min_nxt    = '0;
    ctrl.op        = OP_HOLD;
    ctrl.arm       = 1'b0;
    ctrl.last_idx  = last_cnt[IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_INSERT) begin
            out_strobe_nxt = 1'b1;
            if (count_r >= eff_limit) begin
              out_status_nxt = ST_DROPPED;
            end else begin
              ctrl.op        = OP_PUSH;
              count_nxt      = count_r + 1'b1;
              out_status_nxt = ST_INSERTED;
            end
          end else if (count_r == '0) begin
            out_strobe_nxt = 1'b1;
            out_status_nxt = ST_EMPTY;
          end else if (count_r == CNT_W'(1)) begin
            // A single entry is already the minimum.
            ctrl.op        = OP_POP;
            count_nxt      = '0;
            out_strobe_nxt = 1'b1;
            out_status_nxt = ST_REMOVED;
            out_min_nxt    = vals[0];
          end else begin
            ctrl.arm  = 1'b1;
            rem_nxt   = last_cnt[IDX_W-1:0];
            state_nxt = S_BUBBLE;
          end
        end
      end
      S_BUBBLE: begin
        ctrl.op = OP_BUBBLE;
        rem_nxt = rem_r - 1'b1;
        if (rem_r == IDX_W'(1)) begin
          state_nxt = S_EXTRACT;
        end
      end
      S_EXTRACT: begin
        // The minimum sits in the first cell; pop it and close the gap.
        ctrl.op        = OP_POP;
        count_nxt      = last_cnt;
        out_strobe_nxt = 1'b1;
        out_status_nxt = ST_REMOVED;
        out_min_nxt    = vals[0];
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      data_t lo_v, hi_v;
      logic  hi_s, hi_t;
      if (gi == 0) begin : g_first
        assign lo_v = in_value;
      end else begin : g_mid
        assign lo_v = vals[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign hi_v = vals[gi];
        assign hi_s = 1'b0;
        assign hi_t = 1'b0;
      end else begin : g_body
        assign hi_v = vals[gi+1];
        assign hi_s = swaps[gi+1];
        assign hi_t = toks[gi+1];
      end
      upq_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .cell_idx (IDX_W'(gi)),
        .lo_val   (lo_v),
        .hi_val   (hi_v),
        .hi_swap  (hi_s),
        .hi_tok   (hi_t),
        .val      (vals[gi]),
        .swap     (swaps[gi]),
        .tok      (toks[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      rem_r        <= '0;
      limit_r      <= CFG_W'(CAPACITY);
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      rem_r        <= rem_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_min_r    <= out_min_nxt;
    out_count_r  <= count_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_min_value   = out_min_r;
  assign out_entry_count = out_count_r;

  `UPQ_ASSERT_ALWAYS(a_tok_onehot0, clk, rst_n, $onehot0(toks), "more than one compare token")
  `UPQ_ASSERT_IMPLIES(a_tok_in_bubble, clk, rst_n, state_r == S_BUBBLE, $onehot(toks), "bubble step without a token")
  `UPQ_ASSERT_ALWAYS(a_count_range, clk, rst_n, count_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `UPQ_ASSERT_IMPLIES(a_strobe_idle, clk, rst_n, out_strobe_r, state_r == S_IDLE, "result beat while busy")
  `UPQ_ASSERT_IMPLIES(a_extract_tok, clk, rst_n, state_r == S_EXTRACT, toks[0] && (count_r >= CNT_W'(2)), "pop without the token at the first cell")

endmodule
